// ===== rtl/core/csd_pkg.sv =====
`timescale 1ns / 1ps
package csd_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_SPARE  = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_BAD_RD  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RK_I,
    ST_RK_CAP,
    ST_RK_JRD,
    ST_RK_JCMP,
    ST_RK_WR,
    ST_DD_A,
    ST_DD_B,
    ST_DD_C,
    ST_FIN,
    ST_RD_B,
    ST_RD_C,
    ST_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic pt_rd_i;
    logic cap_i;
    logic pt_rd_j;
    logic cmp_j;
    logic wr_rank;
    logic sb_rd;
    logic pt_rd_sb;
    logic dd_cmp;
    logic fin;
    logic pt_rd_ord;
    logic rd_res;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] kind;
    logic       n_zero;
    logic       rd_ok;
    logic       j_last;
    logic       i_last;
    logic       k_last;
  } sts_t;

  // binary64 bits -> unsigned key in numeric order; all NaNs last and equal,
  // both zeros equal
  function automatic logic [63:0] order_key(input logic [63:0] b);
    logic [62:0] mag;
    logic [63:0] k;
    mag = b[62:0];
    if (mag > 63'h7FF0000000000000) k = 64'hFFFF_FFFF_FFFF_FFFF;
    else if (mag == 63'd0) k = 64'h8000_0000_0000_0000;
    else if (b[63]) k = ~b;
    else k = {1'b1, b[62:0]};
    return k;
  endfunction

endpackage

// ===== rtl/core/csd_in_if.sv =====
`timescale 1ns / 1ps
interface csd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] lon_bits;
  logic [63:0] lat_bits;
  logic [63:0] value_bits;
  logic [csd_pkg::IDX_W-1:0] read_index;

  modport source (output valid, kind, lon_bits, lat_bits, value_bits, read_index,
                  input ready);
  modport sink (input valid, kind, lon_bits, lat_bits, value_bits, read_index,
                output ready);
endinterface

// ===== rtl/core/csd_out_if.sv =====
`timescale 1ns / 1ps
interface csd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_lon_bits;
  logic [63:0] out_lat_bits;
  logic [63:0] out_value_bits;
  logic [csd_pkg::CNT_W-1:0] unique_count;
  logic [1:0]  status;

  modport source (output valid, out_lon_bits, out_lat_bits, out_value_bits,
                  unique_count, status, input ready);
  modport sink (input valid, out_lon_bits, out_lat_bits, out_value_bits,
                unique_count, status, output ready);
endinterface

// ===== rtl/core/coordinate_sort_dedupe.sv =====
`timescale 1ns / 1ps
// Point store with sort and dedupe by (longitude, latitude). One request in
// flight at a time; each gives exactly one result. A load is accepted and
// answered from the result register; a read first fetches the point into
// it; an answer waits while the output stalls. A finish runs, for each
// stored point, a rank pass that reads every stored point through the
// single point-store read port, then a dedupe pass over the sorted index
// buffer. Coordinates compare as doubles with -0 equal to +0; equal pairs
// keep the earliest-loaded point. Loads past capacity answer status 1;
// reads before a finish or past the unique count answer 2.
module coordinate_sort_dedupe (
  input  logic       clk,
  input  logic       rst,
  csd_in_if.sink     in_ch,
  csd_out_if.source  out_ch
);

  csd_pkg::cmd_t cmd;
  csd_pkg::sts_t sts;

  // sequencer: request acceptance, sort/dedupe walk, result hand-off
  csd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // stores, rank and dedupe compare, result register
  csd_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .kind           (in_ch.kind),
    .lon_bits       (in_ch.lon_bits),
    .lat_bits       (in_ch.lat_bits),
    .value_bits     (in_ch.value_bits),
    .read_index     (in_ch.read_index),
    .out_lon_bits   (out_ch.out_lon_bits),
    .out_lat_bits   (out_ch.out_lat_bits),
    .out_value_bits (out_ch.out_value_bits),
    .unique_count   (out_ch.unique_count),
    .status         (out_ch.status)
  );

endmodule

// ===== rtl/core/csd_ctrl.sv =====
`timescale 1ns / 1ps
module csd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  csd_pkg::sts_t   sts,
  output csd_pkg::cmd_t   cmd
);

  csd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= csd_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      csd_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (sts.kind)
            csd_pkg::KIND_FINISH:
              state_next = sts.n_zero ? csd_pkg::ST_RESP : csd_pkg::ST_RK_I;
            csd_pkg::KIND_READ:
              state_next = sts.rd_ok ? csd_pkg::ST_RD_B : csd_pkg::ST_RESP;
            default: state_next = csd_pkg::ST_RESP;
          endcase
        end
      end
      csd_pkg::ST_RK_I:    state_next = csd_pkg::ST_RK_CAP;
      csd_pkg::ST_RK_CAP:  state_next = csd_pkg::ST_RK_JRD;
      csd_pkg::ST_RK_JRD:  state_next = csd_pkg::ST_RK_JCMP;
      csd_pkg::ST_RK_JCMP:
        state_next = sts.j_last ? csd_pkg::ST_RK_WR : csd_pkg::ST_RK_JRD;
      csd_pkg::ST_RK_WR:
        state_next = sts.i_last ? csd_pkg::ST_DD_A : csd_pkg::ST_RK_I;
      csd_pkg::ST_DD_A:    state_next = csd_pkg::ST_DD_B;
      csd_pkg::ST_DD_B:    state_next = csd_pkg::ST_DD_C;
      csd_pkg::ST_DD_C:
        state_next = sts.k_last ? csd_pkg::ST_FIN : csd_pkg::ST_DD_A;
      csd_pkg::ST_FIN:     state_next = csd_pkg::ST_RESP;
      csd_pkg::ST_RD_B:    state_next = csd_pkg::ST_RD_C;
      csd_pkg::ST_RD_C:    state_next = csd_pkg::ST_RESP;
      csd_pkg::ST_RESP:
        if (out_ready) state_next = csd_pkg::ST_IDLE;
      default: state_next = csd_pkg::ST_IDLE;
    endcase
  end

  // no request is taken while reset is held
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      csd_pkg::ST_IDLE: begin
        in_ready   = !rst;
        cmd.accept = in_valid && !rst;
      end
      csd_pkg::ST_RK_I:    cmd.pt_rd_i   = 1'b1;
      csd_pkg::ST_RK_CAP:  cmd.cap_i     = 1'b1;
      csd_pkg::ST_RK_JRD:  cmd.pt_rd_j   = 1'b1;
      csd_pkg::ST_RK_JCMP: cmd.cmp_j     = 1'b1;
      csd_pkg::ST_RK_WR:   cmd.wr_rank   = 1'b1;
      csd_pkg::ST_DD_A:    cmd.sb_rd     = 1'b1;
      csd_pkg::ST_DD_B:    cmd.pt_rd_sb  = 1'b1;
      csd_pkg::ST_DD_C:    cmd.dd_cmp    = 1'b1;
      csd_pkg::ST_FIN:     cmd.fin       = 1'b1;
      csd_pkg::ST_RD_B:    cmd.pt_rd_ord = 1'b1;
      csd_pkg::ST_RD_C:    cmd.rd_res    = 1'b1;
      csd_pkg::ST_RESP:    out_valid     = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/csd_dp.sv =====
`timescale 1ns / 1ps
module csd_dp (
  input  logic          clk,
  input  logic          rst,
  input  csd_pkg::cmd_t cmd,
  output csd_pkg::sts_t sts,
  input  logic [1:0]    kind,
  input  logic [63:0]   lon_bits,
  input  logic [63:0]   lat_bits,
  input  logic [63:0]   value_bits,
  input  logic [csd_pkg::IDX_W-1:0] read_index,
  output logic [63:0]   out_lon_bits,
  output logic [63:0]   out_lat_bits,
  output logic [63:0]   out_value_bits,
  output logic [csd_pkg::CNT_W-1:0] unique_count,
  output logic [1:0]    status
);

  localparam int IW = csd_pkg::IDX_W;
  localparam int CW = csd_pkg::CNT_W;

  logic [63:0]   lon_mem [csd_pkg::MAX_POINTS];
  logic [63:0]   lat_mem [csd_pkg::MAX_POINTS];
  logic [63:0]   val_mem [csd_pkg::MAX_POINTS];
  logic [IW-1:0] sb_mem  [csd_pkg::MAX_POINTS];
  logic [IW-1:0] ord_mem [csd_pkg::MAX_POINTS];

  logic [63:0]   lon_q, lat_q, val_q;
  logic [IW-1:0] sb_q, ord_q, p_reg;
  logic [CW-1:0] loaded_count, distinct_count, cnt;
  logic          finished;
  logic [IW-1:0] i, j, k, rank;
  logic [127:0]  key_i, prev, kj;
  logic          full, pt_en;
  logic [IW-1:0] pt_addr;
  logic [CW-1:0] n_m1;

  assign full   = loaded_count == CW'(csd_pkg::MAX_POINTS);
  assign n_m1   = loaded_count - CW'(1);
  assign kj     = {csd_pkg::order_key(lon_q), csd_pkg::order_key(lat_q)};

  assign sts.kind   = kind;
  assign sts.n_zero = loaded_count == '0;
  assign sts.rd_ok  = finished && ({1'b0, read_index} < distinct_count);
  assign sts.j_last = {1'b0, j} == n_m1;
  assign sts.i_last = {1'b0, i} == n_m1;
  assign sts.k_last = {1'b0, k} == n_m1;

  assign pt_en = cmd.pt_rd_i | cmd.pt_rd_j | cmd.pt_rd_sb | cmd.pt_rd_ord;
  always_comb begin
    if (cmd.pt_rd_i) pt_addr = i;
    else if (cmd.pt_rd_j) pt_addr = j;
    else if (cmd.pt_rd_sb) pt_addr = sb_q;
    else pt_addr = ord_q;
  end

  // point stores: one write (load), one read
  always_ff @(posedge clk) begin
    if (cmd.accept && kind == csd_pkg::KIND_LOAD && !full) begin
      lon_mem[loaded_count[IW-1:0]] <= lon_bits;
      lat_mem[loaded_count[IW-1:0]] <= lat_bits;
      val_mem[loaded_count[IW-1:0]] <= value_bits;
    end
    if (pt_en) begin
      lon_q <= lon_mem[pt_addr];
      lat_q <= lat_mem[pt_addr];
      val_q <= val_mem[pt_addr];
    end
  end

  // sorted index buffer and unique order store
  always_ff @(posedge clk) begin
    if (cmd.wr_rank) sb_mem[rank] <= i;
    if (cmd.sb_rd) sb_q <= sb_mem[k];
    if (cmd.dd_cmp && (k == '0 || kj != prev)) ord_mem[cnt[IW-1:0]] <= p_reg;
    if (cmd.accept) ord_q <= ord_mem[read_index];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count   <= '0;
      distinct_count <= '0;
      finished       <= 1'b0;
      cnt            <= '0;
    end else begin
      if (cmd.accept && kind == csd_pkg::KIND_LOAD && !full) begin
        loaded_count <= loaded_count + CW'(1);
        finished     <= 1'b0;
      end
      if (cmd.accept && kind == csd_pkg::KIND_FINISH) begin
        cnt <= '0;
        if (loaded_count == '0) begin
          distinct_count <= '0;
          finished       <= 1'b1;
        end
      end
      if (cmd.dd_cmp && (k == '0 || kj != prev)) cnt <= cnt + CW'(1);
      if (cmd.fin) begin
        distinct_count <= cnt;
        finished       <= 1'b1;
      end
    end
  end

  // walk counters and keys
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      i <= '0;
      k <= '0;
    end
    if (cmd.cap_i) begin
      key_i <= kj;
      rank  <= '0;
      j     <= '0;
    end
    if (cmd.cmp_j) begin
      if (kj < key_i || (kj == key_i && j < i)) rank <= rank + IW'(1);
      j <= j + IW'(1);
    end
    if (cmd.wr_rank) i <= i + IW'(1);
    if (cmd.pt_rd_sb) p_reg <= sb_q;
    if (cmd.dd_cmp) begin
      prev <= kj;
      k    <= k + IW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_lon_bits   <= '0;
      out_lat_bits   <= '0;
      out_value_bits <= '0;
      unique_count   <= distinct_count;
      status         <= csd_pkg::STAT_OK;
      case (kind)
        csd_pkg::KIND_LOAD:
          if (full) status <= csd_pkg::STAT_FULL;
        csd_pkg::KIND_FINISH:
          if (loaded_count == '0) unique_count <= '0;
        csd_pkg::KIND_READ:
          if (!sts.rd_ok) status <= csd_pkg::STAT_BAD_RD;
        default: ;
      endcase
    end
    if (cmd.fin) unique_count <= cnt;
    if (cmd.rd_res) begin
      out_lon_bits   <= lon_q;
      out_lat_bits   <= lat_q;
      out_value_bits <= val_q;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= loaded_count) else $error("unique count exceeds loaded points");
  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    distinct_count <= loaded_count) else $error("distinct count exceeds loaded points");
  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_rank |-> ({1'b0, rank} < loaded_count)) else $error("rank out of range");

endmodule
